// ===== rtl/bdq_pkg.sv =====
// bdq_pkg: shared types and constants of the bounded deque block
// command and status codes, cell control struct, default sizes
// no dependencies
package bdq_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int WORD_W         = 32;  // fixed width of the item value and data ports
  localparam int CMD_W          = 3;
  localparam int POS_W          = 8;
  localparam int STATUS_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_FRONT = 3'd0,
    CMD_APPEND_END   = 3'd1,
    CMD_READ_POS     = 3'd2,
    CMD_STREAM_ALL   = 3'd3,
    CMD_REMOVE_FRONT = 3'd4,
    CMD_REMOVE_END   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_PUSH   = 2'd1,
    CELL_POP    = 2'd2,
    CELL_APPEND = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     append_here;
  } cell_ctrl_t;

endpackage

// ===== rtl/bdq_cell.sv =====
// bdq_cell: one storage cell of the deque chain
// shifts towards the end on a front insert, towards the front on a front removal
// depends on bdq_pkg
module bdq_cell #(
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  bdq_pkg::cell_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0]  left_d,
  input  logic [DATA_WIDTH-1:0]  right_d,
  input  logic [DATA_WIDTH-1:0]  new_d,
  output logic [DATA_WIDTH-1:0]  q
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.op)
      bdq_pkg::CELL_HOLD:   data_nxt = data_r;
      bdq_pkg::CELL_PUSH:   data_nxt = left_d;
      bdq_pkg::CELL_POP:    data_nxt = right_d;
      bdq_pkg::CELL_APPEND: data_nxt = ctrl.append_here ? new_d : data_r;
      default:              data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== rtl/bounded_deque_with_indexed_read_top.sv =====
// bounded_deque_with_indexed_read_top: bounded deque of signed words with indexed read
// chain of bdq_cell instances, element count and output register
// depends on bdq_pkg and bdq_cell
//
// usage
//   input channel in_valid/in_stall carries in_cmd, in_item_value, in_position;
//   result channel out_valid/out_stall carries out_status, out_data_out,
//   out_count_now, out_final_flag. an item moves on an edge with valid high
//   and stall low.
//   the front element always sits in cell 0; a front insert shifts the whole
//   chain one cell towards the end, a front removal one cell back.
//   every command except stream gives one result, ready in the output register
//   in the cycle after the item is taken, so items go in at one per cycle while
//   the receiver keeps up.
//   a stream of n elements gives n results, one per cycle while the receiver
//   keeps up, the first in the cycle after the item is taken; the read mux over
//   the chain, stepped by the stream counter, picks each one. in_stall stays high
//   until the last one is loaded into the output register.
//   while out_stall holds a result, in_stall is high and nothing moves.
//   reset empties the deque and drops any pending result; the cell contents
//   themselves are not cleared.
module bounded_deque_with_indexed_read_top #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bdq_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [bdq_pkg::WORD_W-1:0] in_item_value,
  input  logic [bdq_pkg::POS_W-1:0]     in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdq_pkg::STATUS_W-1:0]  out_status,
  output logic signed [bdq_pkg::WORD_W-1:0] out_data_out,
  output logic [CNT_W-1:0]              out_count_now,
  output logic                          out_final_flag
);

  localparam int CMP_W = 16;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  streaming_r, streaming_nxt;
  logic [IDX_W-1:0]      str_idx_r, str_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [bdq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bdq_pkg::WORD_W-1:0]   out_data_r, out_data_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;
  logic                  out_final_r, out_final_nxt;

  logic                  out_free;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [IDX_W-1:0]      rd_idx;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [bdq_pkg::WORD_W-1:0] rd_word;
  logic [63:0]           in_ext;
  logic [63:0]           rd_ext;
  logic [DATA_WIDTH-1:0] new_d;
  logic [IDX_W-1:0]      wr_idx;
  logic                  str_last;
  bdq_pkg::cell_op_t     cell_op;
  bdq_pkg::cell_ctrl_t   cell_ctrl [DEPTH];
  logic [DATA_WIDTH-1:0] cell_q    [DEPTH];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = streaming_r || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  // item value kept as its low DATA_WIDTH bits, sign-extended on the way out
  assign in_ext  = 64'(in_item_value);
  assign new_d   = in_ext[DATA_WIDTH-1:0];
  assign wr_idx  = count_r[IDX_W-1:0];

  always_comb begin
    if (streaming_r) begin
      rd_idx = str_idx_r;
    end else if (bdq_pkg::cmd_t'(in_cmd) == bdq_pkg::CMD_STREAM_ALL) begin
      rd_idx = '0;
    end else begin
      rd_idx = IDX_W'(in_position);
    end
  end

  assign rd_data = cell_q[rd_idx];
  assign rd_ext  = 64'(signed'(rd_data));
  assign rd_word = rd_ext[bdq_pkg::WORD_W-1:0];
  assign str_last = ((CNT_W'(str_idx_r) + CNT_W'(1)) == count_r);

  // cell chain: cell 0 takes the new word on a front insert, the last cell holds on a pop
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].op          = cell_op;
    assign cell_ctrl[i].append_here = (wr_idx == IDX_W'(i));

    if (i == 0 && DEPTH == 1) begin : g_only
      bdq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk(clk), .ctrl(cell_ctrl[i]), .left_d(new_d), .right_d(cell_q[i]),
        .new_d(new_d), .q(cell_q[i])
      );
    end else if (i == 0) begin : g_head
      bdq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk(clk), .ctrl(cell_ctrl[i]), .left_d(new_d), .right_d(cell_q[i+1]),
        .new_d(new_d), .q(cell_q[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      bdq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk(clk), .ctrl(cell_ctrl[i]), .left_d(cell_q[i-1]), .right_d(cell_q[i]),
        .new_d(new_d), .q(cell_q[i])
      );
    end else begin : g_mid
      bdq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk(clk), .ctrl(cell_ctrl[i]), .left_d(cell_q[i-1]), .right_d(cell_q[i+1]),
        .new_d(new_d), .q(cell_q[i])
      );
    end
  end

  always_comb begin
    count_nxt      = count_r;
    streaming_nxt  = streaming_r;
    str_idx_nxt    = str_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    out_final_nxt  = out_final_r;
    cell_op        = bdq_pkg::CELL_HOLD;

    if (streaming_r) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = bdq_pkg::ST_OK;
        out_data_nxt   = rd_word;
        out_count_nxt  = count_r;
        out_final_nxt  = str_last;
        str_idx_nxt    = str_idx_r + IDX_W'(1);
        streaming_nxt  = !str_last;
      end
    end else if (accept) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = bdq_pkg::ST_OK;
      out_data_nxt   = '0;
      out_final_nxt  = 1'b1;
      unique case (bdq_pkg::cmd_t'(in_cmd))
        bdq_pkg::CMD_INSERT_FRONT: begin
          if (full) begin
            out_status_nxt = bdq_pkg::ST_FULL;
          end else begin
            cell_op   = bdq_pkg::CELL_PUSH;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        bdq_pkg::CMD_APPEND_END: begin
          if (full) begin
            out_status_nxt = bdq_pkg::ST_FULL;
          end else begin
            cell_op   = bdq_pkg::CELL_APPEND;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        bdq_pkg::CMD_READ_POS: begin
          if (empty) begin
            out_status_nxt = bdq_pkg::ST_EMPTY;
          end else if (CMP_W'(in_position) >= CMP_W'(count_r)) begin
            out_status_nxt = bdq_pkg::ST_BOUNDS;
          end else begin
            out_data_nxt = rd_word;
          end
        end
        bdq_pkg::CMD_STREAM_ALL: begin
          if (empty) begin
            out_status_nxt = bdq_pkg::ST_EMPTY;
          end else begin
            // first element goes out now, the rest one per cycle while the receiver keeps up
            out_data_nxt  = rd_word;
            out_final_nxt = (count_r == CNT_W'(1));
            streaming_nxt = (count_r != CNT_W'(1));
            str_idx_nxt   = IDX_W'(1);
          end
        end
        bdq_pkg::CMD_REMOVE_FRONT: begin
          if (empty) begin
            out_status_nxt = bdq_pkg::ST_EMPTY;
          end else begin
            cell_op   = bdq_pkg::CELL_POP;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        bdq_pkg::CMD_REMOVE_END: begin
          if (empty) begin
            out_status_nxt = bdq_pkg::ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          out_status_nxt = bdq_pkg::ST_OK;
        end
      endcase
      out_count_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      streaming_r <= 1'b0;
      str_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      streaming_r <= streaming_nxt;
      str_idx_r   <= str_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_out   = out_data_r;
  assign out_count_now  = out_count_r;
  assign out_final_flag = out_final_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_stream_idx: assert property (@(posedge clk) disable iff (!rst_n)
    streaming_r |-> (CNT_W'(str_idx_r) < count_r))
    else $error("stream index past the last element");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !full && (bdq_pkg::cmd_t'(in_cmd) == bdq_pkg::CMD_INSERT_FRONT))
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("front insert did not grow the count");

  a_stream_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    streaming_r |-> in_stall)
    else $error("item taken during a stream");

endmodule
